// ===== design/pfx_pkg.sv =====
// Shared types, codes and constants of the postfix expression evaluator.
package pfx_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_VARS_DEF    = 26;
  localparam int FRAC_BITS_DEF   = 32;
  localparam int DATA_W          = 64;

  typedef logic [DATA_W-1:0] pfx_word_t;

  localparam pfx_word_t SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam pfx_word_t SAT_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_APPLY = 2'd2
  } pfx_mode_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } pfx_op_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_DIV_ZERO  = 2'd3
  } pfx_err_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } pfx_cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ALU  = 2'd1,
    ST_EMIT = 2'd2
  } pfx_state_t;

  typedef enum logic [3:0] {
    ALU_IDLE      = 4'd0,
    ALU_ADDSUB    = 4'd1,
    ALU_MUL       = 4'd2,
    ALU_MUL_FIX_A = 4'd3,
    ALU_MUL_FIX_B = 4'd4,
    ALU_MUL_END   = 4'd5,
    ALU_DIV_SETUP = 4'd6,
    ALU_DIV_CHECK = 4'd7,
    ALU_DIV       = 4'd8,
    ALU_DIV_END   = 4'd9,
    ALU_DONE      = 4'd10
  } pfx_alu_state_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } pfx_alu_stat_t;

endpackage

// ===== design/pfx_cell.sv =====
// One stack cell: holds one entry, takes it from the neighbour above or below.
module pfx_cell (
  input  logic                  clk,
  input  pfx_pkg::pfx_cell_cmd_t cmd,
  input  pfx_pkg::pfx_word_t    prev_data,
  input  pfx_pkg::pfx_word_t    next_data,
  output pfx_pkg::pfx_word_t    data
);

  pfx_pkg::pfx_word_t data_r;
  pfx_pkg::pfx_word_t data_nxt;

  always_comb begin
    case (cmd)
      pfx_pkg::CELL_PUSH: data_nxt = prev_data;
      pfx_pkg::CELL_POP:  data_nxt = next_data;
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== design/pfx_alu.sv =====
// Multi-cycle fixed-point unit: saturating add/subtract, multiply, divide.
module pfx_alu #(
  parameter int FRAC_BITS = pfx_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  pfx_pkg::pfx_op_t      op,
  input  pfx_pkg::pfx_word_t    opa,
  input  pfx_pkg::pfx_word_t    opb,
  output pfx_pkg::pfx_word_t    result,
  output pfx_pkg::pfx_alu_stat_t stat
);

  localparam int W         = pfx_pkg::DATA_W;
  localparam int HI_SH     = W - FRAC_BITS;
  localparam int DIV_STEPS = W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  pfx_pkg::pfx_alu_state_t state_r, state_nxt;

  pfx_pkg::pfx_word_t a_r, b_r, res_r, rem_r, sh_r, q_r, d_r, pp_r;
  pfx_pkg::pfx_op_t   op_r;
  logic [2*W-1:0]     acc_r;
  logic [1:0]         pp_sh_r;
  logic               pp_v_r;
  logic [2:0]         mcnt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r, big_r, dz_r;

  function automatic pfx_pkg::pfx_word_t sat_add(pfx_pkg::pfx_word_t a,
                                                 pfx_pkg::pfx_word_t b);
    pfx_pkg::pfx_word_t r;
    r = a + b;
    if ((a[W-1] == b[W-1]) && (r[W-1] != a[W-1]))
      r = a[W-1] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX;
    return r;
  endfunction

  function automatic pfx_pkg::pfx_word_t sat_sub(pfx_pkg::pfx_word_t a,
                                                 pfx_pkg::pfx_word_t b);
    pfx_pkg::pfx_word_t r;
    r = a - b;
    if ((a[W-1] != b[W-1]) && (r[W-1] != a[W-1]))
      r = a[W-1] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX;
    return r;
  endfunction

  // Datapath terms
  logic [31:0]         mul_x, mul_y;
  logic [W-1:0]        mul_p;
  logic [2*W-1:0]      pp_shifted;
  logic [2*W-1:0]      acc_shr, acc_top;
  logic                mul_ovf;
  pfx_pkg::pfx_word_t  mul_res, addsub_res, mag_a, mag_b, nhi, nlo, div_res;
  logic [W:0]          div_t, div_diff;
  logic                div_ge;

  always_comb begin
    mul_x      = mcnt_r[1] ? a_r[W-1:32] : a_r[31:0];
    mul_y      = mcnt_r[0] ? b_r[W-1:32] : b_r[31:0];
    mul_p      = mul_x * mul_y;
    pp_shifted = {{W{1'b0}}, pp_r} << {pp_sh_r, 5'd0};

    acc_shr = $signed(acc_r) >>> FRAC_BITS;
    acc_top = $signed(acc_r) >>> (FRAC_BITS + W - 1);
    mul_ovf = !((acc_top == '0) || (acc_top == '1));
    mul_res = mul_ovf ? (acc_r[2*W-1] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX)
                      : acc_shr[W-1:0];

    addsub_res = (op_r == pfx_pkg::OP_SUB) ? sat_sub(a_r, b_r) : sat_add(a_r, b_r);

    mag_a = a_r[W-1] ? (~a_r + 1'b1) : a_r;
    mag_b = b_r[W-1] ? (~b_r + 1'b1) : b_r;
    nhi   = sh_r >> HI_SH;
    nlo   = sh_r << FRAC_BITS;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    div_t    = {rem_r, sh_r[W-1]};
    div_diff = div_t - {1'b0, d_r};
    div_ge   = ~div_diff[W];

    if (neg_r)
      div_res = (big_r || (q_r > pfx_pkg::SAT_MIN)) ? pfx_pkg::SAT_MIN : (~q_r + 1'b1);
    else
      div_res = (big_r || q_r[W-1]) ? pfx_pkg::SAT_MAX : q_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfx_pkg::ALU_IDLE: begin
        if (start) begin
          case (op)
            pfx_pkg::OP_MUL: state_nxt = pfx_pkg::ALU_MUL;
            pfx_pkg::OP_DIV: state_nxt = pfx_pkg::ALU_DIV_SETUP;
            default:         state_nxt = pfx_pkg::ALU_ADDSUB;
          endcase
        end
      end
      pfx_pkg::ALU_ADDSUB:    state_nxt = pfx_pkg::ALU_DONE;
      pfx_pkg::ALU_MUL:       if (mcnt_r == 3'd4) state_nxt = pfx_pkg::ALU_MUL_FIX_A;
      pfx_pkg::ALU_MUL_FIX_A: state_nxt = pfx_pkg::ALU_MUL_FIX_B;
      pfx_pkg::ALU_MUL_FIX_B: state_nxt = pfx_pkg::ALU_MUL_END;
      pfx_pkg::ALU_MUL_END:   state_nxt = pfx_pkg::ALU_DONE;
      pfx_pkg::ALU_DIV_SETUP: state_nxt = (b_r == '0) ? pfx_pkg::ALU_DONE
                                                      : pfx_pkg::ALU_DIV_CHECK;
      pfx_pkg::ALU_DIV_CHECK: state_nxt = (nhi >= d_r) ? pfx_pkg::ALU_DIV_END
                                                       : pfx_pkg::ALU_DIV;
      pfx_pkg::ALU_DIV:       if (cnt_r == CNT_W'(DIV_STEPS - 1))
                                state_nxt = pfx_pkg::ALU_DIV_END;
      pfx_pkg::ALU_DIV_END:   state_nxt = pfx_pkg::ALU_DONE;
      pfx_pkg::ALU_DONE:      state_nxt = pfx_pkg::ALU_IDLE;
      default:                state_nxt = pfx_pkg::ALU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfx_pkg::ALU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Operand and iteration registers
  always_ff @(posedge clk) begin
    case (state_r)
      pfx_pkg::ALU_IDLE: begin
        if (start) begin
          a_r    <= opa;
          b_r    <= opb;
          op_r   <= op;
          acc_r  <= '0;
          mcnt_r <= '0;
          pp_v_r <= 1'b0;
          dz_r   <= 1'b0;
        end
      end
      pfx_pkg::ALU_ADDSUB: res_r <= addsub_res;
      pfx_pkg::ALU_MUL: begin
        pp_r    <= mul_p;
        pp_sh_r <= {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
        pp_v_r  <= (mcnt_r != 3'd4);
        mcnt_r  <= mcnt_r + 3'd1;
        if (pp_v_r)
          acc_r <= acc_r + pp_shifted;
      end
      pfx_pkg::ALU_MUL_FIX_A: if (a_r[W-1]) acc_r[2*W-1:W] <= acc_r[2*W-1:W] - b_r;
      pfx_pkg::ALU_MUL_FIX_B: if (b_r[W-1]) acc_r[2*W-1:W] <= acc_r[2*W-1:W] - a_r;
      pfx_pkg::ALU_MUL_END:   res_r <= mul_res;
      pfx_pkg::ALU_DIV_SETUP: begin
        if (b_r == '0) begin
          dz_r  <= 1'b1;
          res_r <= (a_r == '0) ? '0 : (a_r[W-1] ? pfx_pkg::SAT_MIN : pfx_pkg::SAT_MAX);
        end
        sh_r  <= mag_a;
        d_r   <= mag_b;
        neg_r <= a_r[W-1] ^ b_r[W-1];
      end
      pfx_pkg::ALU_DIV_CHECK: begin
        big_r <= (nhi >= d_r);
        rem_r <= nhi;
        sh_r  <= nlo;
        q_r   <= '0;
        cnt_r <= '0;
      end
      pfx_pkg::ALU_DIV: begin
        rem_r <= div_ge ? div_diff[W-1:0] : div_t[W-1:0];
        q_r   <= {q_r[W-2:0], div_ge};
        sh_r  <= {sh_r[W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      pfx_pkg::ALU_DIV_END: res_r <= div_res;
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    stat.done     = (state_r == pfx_pkg::ALU_DONE);
    stat.div_zero = dz_r;
    result        = res_r;
  end

endmodule

// ===== design/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator: control, variable table, stack chain.
//
// Usage:
//   Input channel (in_*): one token per transfer. in_mode selects load of a
//   variable value, push of a variable (converted to signed fixed point with
//   FRAC_BITS fraction bits), or applying in_operator to the two top entries.
//   in_last marks the final token of an expression.
//   Result channel (out_*): one transfer per expression, carrying the top of
//   stack and the first error seen; the stack and error are then emptied.
// Timing:
//   Load and push do not stall the input. Add and subtract pass once through
//   the operator unit; multiply forms four 32x32 partial products, each
//   registered before it is accumulated; the divider retires one quotient bit
//   per cycle over 64 steps. A token marked last is followed by a result write.
//   Tokens are handled one at a time: in_stall stays high while one is at work.
// Reset: synchronous, active low; the stack becomes empty and the error clears.
//   Stack and variable contents need no clearing pass.
// Back-pressure: the result sits in an output register while out_stall is
//   high; further tokens are still taken until another result is ready.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
  parameter int NUM_VARS    = pfx_pkg::NUM_VARS_DEF,
  parameter int FRAC_BITS   = pfx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_var_index,
  input  logic signed [15:0] in_var_value,
  input  logic [1:0]         in_operator,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_result_value,
  output logic [1:0]         out_error_code
);

  localparam int W     = pfx_pkg::DATA_W;
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int VAR_W = 16;
  localparam int VIW   = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  pfx_pkg::pfx_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  pfx_pkg::pfx_err_t   err_r, err_nxt;
  logic                last_r;
  logic                out_valid_r, out_valid_nxt;
  pfx_pkg::pfx_word_t  out_value_r;
  pfx_pkg::pfx_err_t   out_err_r;

  logic [VAR_W-1:0]    var_tbl_r [NUM_VARS];

  pfx_pkg::pfx_word_t  stack_q [STACK_DEPTH];
  pfx_pkg::pfx_word_t  top_in;
  pfx_pkg::pfx_cell_cmd_t cmd_top, cmd_rest;

  pfx_pkg::pfx_word_t  alu_res;
  pfx_pkg::pfx_alu_stat_t alu_stat;

  logic               accept, var_hit, do_load, do_push, push_ok, alu_start, wb, emit;
  logic [VIW-1:0]     vidx;
  logic [VAR_W-1:0]   var_raw;
  pfx_pkg::pfx_word_t push_val;
  logic               full, few;

  // Token decode
  always_comb begin
    accept  = in_valid && !in_stall;
    var_hit = (in_var_index < 5'(NUM_VARS));
    vidx    = in_var_index[VIW-1:0];
    var_raw = var_tbl_r[vidx];
    // an unknown variable pushes zero
    push_val = var_hit ? (pfx_pkg::pfx_word_t'({{(W-VAR_W){var_raw[VAR_W-1]}}, var_raw})
                          << FRAC_BITS)
                       : '0;
    full      = (count_r >= CW'(STACK_DEPTH));
    few       = (count_r < CW'(2));
    do_load   = accept && (in_mode == pfx_pkg::MODE_LOAD) && var_hit;
    do_push   = accept && (in_mode == pfx_pkg::MODE_PUSH);
    push_ok   = do_push && !full;
    alu_start = accept && (in_mode == pfx_pkg::MODE_APPLY) && !few;
    wb        = (state_r == pfx_pkg::ST_ALU) && alu_stat.done;
    emit      = (state_r == pfx_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfx_pkg::ST_IDLE: begin
        if (alu_start)
          state_nxt = pfx_pkg::ST_ALU;
        else if (accept && in_last)
          state_nxt = pfx_pkg::ST_EMIT;
      end
      pfx_pkg::ST_ALU: begin
        if (alu_stat.done)
          state_nxt = last_r ? pfx_pkg::ST_EMIT : pfx_pkg::ST_IDLE;
      end
      pfx_pkg::ST_EMIT: if (emit) state_nxt = pfx_pkg::ST_IDLE;
      default: state_nxt = pfx_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall = (state_r != pfx_pkg::ST_IDLE);
    top_in   = wb ? alu_res : push_val;
    cmd_top  = (push_ok || wb) ? pfx_pkg::CELL_PUSH : pfx_pkg::CELL_HOLD;
    if (push_ok)
      cmd_rest = pfx_pkg::CELL_PUSH;
    else if (wb)
      cmd_rest = pfx_pkg::CELL_POP;
    else
      cmd_rest = pfx_pkg::CELL_HOLD;
  end

  // Count, sticky error and result register; only the first error is kept
  always_comb begin
    count_nxt     = count_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (push_ok)
      count_nxt = count_r + 1'b1;
    if (wb)
      count_nxt = count_r - 1'b1;
    if (err_r == pfx_pkg::ERR_NONE) begin
      if (do_push && full)
        err_nxt = pfx_pkg::ERR_OVERFLOW;
      else if (accept && (in_mode == pfx_pkg::MODE_APPLY) && few)
        err_nxt = pfx_pkg::ERR_UNDERFLOW;
      else if (wb && alu_stat.div_zero)
        err_nxt = pfx_pkg::ERR_DIV_ZERO;
    end
    if (emit) begin
      count_nxt     = '0;
      err_nxt       = pfx_pkg::ERR_NONE;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfx_pkg::ST_IDLE;
      count_r     <= '0;
      err_r       <= pfx_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: last flag held while the unit works, variable writes, result
  always_ff @(posedge clk) begin
    if (accept)
      last_r <= in_last;
    if (do_load)
      var_tbl_r[vidx] <= in_var_value;
    if (emit) begin
      out_value_r <= (count_r == '0) ? '0 : stack_q[0];
      out_err_r   <= ((err_r == pfx_pkg::ERR_NONE) && (count_r == '0))
                     ? pfx_pkg::ERR_UNDERFLOW : err_r;
    end
  end

  // Stack: a row of cells, top of stack in cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    pfx_pkg::pfx_word_t prev_d, next_d;
    assign prev_d = (i == 0) ? top_in : stack_q[(i == 0) ? 0 : i - 1];
    assign next_d = (i == STACK_DEPTH - 1) ? '0
                                           : stack_q[(i == STACK_DEPTH - 1) ? i : i + 1];
    pfx_cell u_cell (
      .clk       (clk),
      .cmd       ((i == 0) ? cmd_top : cmd_rest),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (stack_q[i])
    );
  end

  // Operator unit: second entry is the left operand
  pfx_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (pfx_pkg::pfx_op_t'(in_operator)),
    .opa    (stack_q[1]),
    .opb    (stack_q[0]),
    .result (alu_res),
    .stat   (alu_stat)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error_code   = out_err_r;

endmodule

// ===== design/pfx_checker.sv =====
// Port-level checks of the postfix expression evaluator, bound to the top level.
module pfx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_mode,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_value,
  input logic [1:0]  out_error_code
);

  // reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) &&
                               $stable(out_error_code))
    else $error("stalled result changed");

  // the token that closes an expression blocks input while its result is written
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input taken during result write");

  // a load that does not close an expression leaves the input free on the next cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last && (in_mode == pfx_pkg::MODE_LOAD) |=> !in_stall)
    else $error("load token held the input");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (.*);
